>>> hw/rtl/hss_pkg.sv
package hss_pkg;

   localparam int HASH_W     = 32;
   localparam int BYTE_W     = 7;
   localparam int VAR_DEPTH  = 256;
   localparam int FUNC_DEPTH = 64;

   localparam int VAR_AW  = (VAR_DEPTH > 1) ? $clog2(VAR_DEPTH) : 1;
   localparam int FUNC_AW = (FUNC_DEPTH > 1) ? $clog2(FUNC_DEPTH) : 1;
   localparam int VAR_CW  = $clog2(VAR_DEPTH + 1);
   localparam int FUNC_CW = $clog2(FUNC_DEPTH + 1);
   localparam int SCAN_CW = (VAR_CW > FUNC_CW) ? VAR_CW : FUNC_CW;

   localparam logic OP_NAME_BYTE = 1'b0;
   localparam logic OP_CLEAR_VAR = 1'b1;
   localparam logic SET_VAR      = 1'b0;
   localparam logic SET_FUNC     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX_A,
      ST_MIX_B,
      ST_FIN_A,
      ST_FIN_B,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DECIDE
   } state_type;

   function automatic logic [HASH_W-1:0] mix_char(input logic [HASH_W-1:0] h,
                                                  input logic [HASH_W-1:0] c);
      logic [HASH_W-1:0] t;
      t = h + c;
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic logic [HASH_W-1:0] finish_hash(input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction

   localparam logic [HASH_W-1:0] MAIN_HASH =
      finish_hash(mix_char(mix_char(mix_char(mix_char(32'h0, 32'h6d), 32'h61),
                                    32'h69), 32'h6e));

endpackage

>>> hw/rtl/hss_ram.sv
module hss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/hashed_symbol_set_top.sv
// Identifier hash and symbol set lookup.
// Input words carry one identifier character each (op = name byte) or a
// request to empty the variable set (op = clear). Characters are folded into
// a one-at-a-time hash with one shared 32-bit adder; the word flagged
// last_byte finishes the hash, which is then compared against each stored
// entry of the chosen set (one RAM read per entry) and optionally inserted.
// Steps: a non-final character occupies the block for its accept step and
// two adder passes. A final character adds two finishing passes, a read and
// a compare step per entry up to and including a match, and the decide step;
// with no match every entry of the set is compared and one more read step
// ends the scan. The entry scan dominates. A clear word is taken in idle.
// req_stall is high while a word is in work.
// One result word per final character; no result for other words.
// The result sits in an output register: the next input word can be taken
// while it waits, but a new result holds in the decide step until rsp_stall
// releases the old one. main_defined tracks whether the hash of main was
// ever inserted into the function set.
// Reset (synchronous) empties both sets, clears the hash and drops
// rsp_valid; no clearing pass is needed.
module hashed_symbol_set_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic [hss_pkg::BYTE_W-1:0] req_name_byte,
   input  logic                       req_last_byte,
   input  logic                       req_which_set,
   input  logic                       req_want_insert,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic                       rsp_inserted,
   output logic                       rsp_set_full,
   output logic [hss_pkg::HASH_W-1:0] rsp_name_hash,
   output logic                       rsp_main_defined
);

   hss_pkg::state_type state_ff, state_in;

   logic [hss_pkg::HASH_W-1:0]  acc_ff, acc_in;
   logic [hss_pkg::BYTE_W-1:0]  byte_ff;
   logic                        last_ff, which_ff, want_ins_ff;
   logic [hss_pkg::SCAN_CW-1:0] idx_ff, idx_in;
   logic                        found_ff, found_in;
   logic [hss_pkg::VAR_CW-1:0]  var_cnt_ff, var_cnt_in;
   logic [hss_pkg::FUNC_CW-1:0] func_cnt_ff, func_cnt_in;
   logic                        main_ff, main_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_inserted_ff, rsp_full_ff, rsp_main_ff;
   logic [hss_pkg::HASH_W-1:0]  rsp_hash_ff;

   logic accept;
   logic out_free;

   // shared adder
   logic [hss_pkg::HASH_W-1:0] add_b, add_sum, unit_out;
   logic [3:0]                 xor_sh;
   logic                       xor_en;

   logic [hss_pkg::SCAN_CW-1:0] sel_cnt, sel_depth;
   logic [hss_pkg::HASH_W-1:0]  var_rd_data, func_rd_data, sel_rd_data;
   logic                        var_wr_en, func_wr_en;
   logic                        do_insert, has_room, ins_ok, ins_full, match;
   logic                        emit;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sel_cnt   = (which_ff == hss_pkg::SET_FUNC) ?
                      hss_pkg::SCAN_CW'(func_cnt_ff) : hss_pkg::SCAN_CW'(var_cnt_ff);
   assign sel_depth = (which_ff == hss_pkg::SET_FUNC) ?
                      hss_pkg::SCAN_CW'(hss_pkg::FUNC_DEPTH) :
                      hss_pkg::SCAN_CW'(hss_pkg::VAR_DEPTH);
   assign sel_rd_data = (which_ff == hss_pkg::SET_FUNC) ? func_rd_data : var_rd_data;
   assign match       = (sel_rd_data == acc_ff);

   assign do_insert = want_ins_ff && !found_ff;
   assign has_room  = sel_cnt < sel_depth;
   assign ins_ok    = do_insert && has_room;
   assign ins_full  = do_insert && !has_room;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hss_pkg::ST_IDLE: begin
            if (accept && req_op == hss_pkg::OP_NAME_BYTE) begin
               state_in = hss_pkg::ST_MIX_A;
            end
         end
         hss_pkg::ST_MIX_A: state_in = hss_pkg::ST_MIX_B;
         hss_pkg::ST_MIX_B: state_in = last_ff ? hss_pkg::ST_FIN_A : hss_pkg::ST_IDLE;
         hss_pkg::ST_FIN_A: state_in = hss_pkg::ST_FIN_B;
         hss_pkg::ST_FIN_B: state_in = hss_pkg::ST_SCAN_RD;
         hss_pkg::ST_SCAN_RD: begin
            state_in = (idx_ff < sel_cnt) ? hss_pkg::ST_SCAN_CMP : hss_pkg::ST_DECIDE;
         end
         hss_pkg::ST_SCAN_CMP: begin
            state_in = match ? hss_pkg::ST_DECIDE : hss_pkg::ST_SCAN_RD;
         end
         hss_pkg::ST_DECIDE: begin
            if (out_free) begin
               state_in = hss_pkg::ST_IDLE;
            end
         end
         default: state_in = hss_pkg::ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      add_b     = '0;
      xor_en    = 1'b0;
      xor_sh    = 4'd0;
      req_stall = 1'b1;
      emit      = 1'b0;
      unique case (state_ff)
         hss_pkg::ST_IDLE: req_stall = 1'b0;
         hss_pkg::ST_MIX_A: add_b = hss_pkg::HASH_W'(byte_ff);
         hss_pkg::ST_MIX_B: begin
            add_b  = acc_ff << 10;
            xor_en = 1'b1;
            xor_sh = 4'd6;
         end
         hss_pkg::ST_FIN_A: begin
            add_b  = acc_ff << 3;
            xor_en = 1'b1;
            xor_sh = 4'd11;
         end
         hss_pkg::ST_FIN_B: add_b = acc_ff << 15;
         hss_pkg::ST_SCAN_RD, hss_pkg::ST_SCAN_CMP: ;
         hss_pkg::ST_DECIDE: emit = out_free;
         default: ;
      endcase
   end

   assign add_sum  = acc_ff + add_b;
   assign unit_out = xor_en ? (add_sum ^ (add_sum >> xor_sh)) : add_sum;

   assign var_wr_en  = emit && ins_ok && (which_ff == hss_pkg::SET_VAR);
   assign func_wr_en = emit && ins_ok && (which_ff == hss_pkg::SET_FUNC);

   // register next values
   always_comb begin
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      var_cnt_in   = var_cnt_ff;
      func_cnt_in  = func_cnt_ff;
      main_in      = main_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         hss_pkg::ST_IDLE: begin
            idx_in   = '0;
            found_in = 1'b0;
            if (accept && req_op == hss_pkg::OP_CLEAR_VAR) begin
               var_cnt_in = '0;
            end
         end
         hss_pkg::ST_MIX_A, hss_pkg::ST_MIX_B,
         hss_pkg::ST_FIN_A, hss_pkg::ST_FIN_B: acc_in = unit_out;
         hss_pkg::ST_SCAN_RD: ;
         hss_pkg::ST_SCAN_CMP: begin
            if (match) begin
               found_in = 1'b1;
            end else begin
               idx_in = idx_ff + hss_pkg::SCAN_CW'(1);
            end
         end
         hss_pkg::ST_DECIDE: begin
            if (emit) begin
               acc_in       = '0;
               rsp_valid_in = 1'b1;
               if (var_wr_en) begin
                  var_cnt_in = var_cnt_ff + hss_pkg::VAR_CW'(1);
               end
               if (func_wr_en) begin
                  func_cnt_in = func_cnt_ff + hss_pkg::FUNC_CW'(1);
                  if (acc_ff == hss_pkg::MAIN_HASH) begin
                     main_in = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hss_pkg::ST_IDLE;
         acc_ff       <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         var_cnt_ff   <= '0;
         func_cnt_ff  <= '0;
         main_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         var_cnt_ff   <= var_cnt_in;
         func_cnt_ff  <= func_cnt_in;
         main_ff      <= main_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff     <= req_name_byte;
         last_ff     <= req_last_byte;
         which_ff    <= req_which_set;
         want_ins_ff <= req_want_insert;
      end
      if (emit) begin
         rsp_found_ff    <= found_ff;
         rsp_inserted_ff <= ins_ok;
         rsp_full_ff     <= ins_full;
         rsp_hash_ff     <= acc_ff;
         rsp_main_ff     <= main_in;
      end
   end

   hss_ram #(
      .WIDTH (hss_pkg::HASH_W),
      .DEPTH (hss_pkg::VAR_DEPTH)
   ) u_var_ram (
      .clock   (clock),
      .wr_en   (var_wr_en),
      .wr_addr (var_cnt_ff[hss_pkg::VAR_AW-1:0]),
      .wr_data (acc_ff),
      .rd_addr (idx_ff[hss_pkg::VAR_AW-1:0]),
      .rd_data (var_rd_data)
   );

   hss_ram #(
      .WIDTH (hss_pkg::HASH_W),
      .DEPTH (hss_pkg::FUNC_DEPTH)
   ) u_func_ram (
      .clock   (clock),
      .wr_en   (func_wr_en),
      .wr_addr (func_cnt_ff[hss_pkg::FUNC_AW-1:0]),
      .wr_data (acc_ff),
      .rd_addr (idx_ff[hss_pkg::FUNC_AW-1:0]),
      .rd_data (func_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_inserted     = rsp_inserted_ff;
   assign rsp_set_full     = rsp_full_ff;
   assign rsp_name_hash    = rsp_hash_ff;
   assign rsp_main_defined = rsp_main_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (var_cnt_ff <= hss_pkg::VAR_CW'(hss_pkg::VAR_DEPTH)) &&
      (func_cnt_ff <= hss_pkg::FUNC_CW'(hss_pkg::FUNC_DEPTH)))
      else $error("set count beyond depth");

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == hss_pkg::ST_DECIDE))
      else $error("result word raised outside decide step");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hss_pkg::ST_SCAN_CMP) |-> (idx_ff < sel_cnt))
      else $error("scan compares an entry beyond the set count");

   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && (rsp_found_ff || rsp_inserted_ff)))
      else $error("full flag with found or inserted");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

   typedef struct {
      logic                       op;
      logic [hss_pkg::BYTE_W-1:0] ch;
      logic                       last;
      logic                       fset;
      logic                       ins;
   } sym_word_type;

   typedef struct {
      logic                       found;
      logic                       inserted;
      logic                       set_full;
      logic [hss_pkg::HASH_W-1:0] hash;
      logic                       main_def;
   } lookup_type;

   typedef struct {
      logic [hss_pkg::BYTE_W-1:0] chars [8];
      int                         len;
   } ident_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_op = hss_pkg::OP_NAME_BYTE;
   logic [hss_pkg::BYTE_W-1:0] req_name_byte = '0;
   logic                       req_last_byte = 1'b0;
   logic                       req_which_set = hss_pkg::SET_VAR;
   logic                       req_want_insert = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_found;
   logic                       rsp_inserted;
   logic                       rsp_set_full;
   logic [hss_pkg::HASH_W-1:0] rsp_name_hash;
   logic                       rsp_main_defined;

   // shadow of the block's state
   logic [hss_pkg::HASH_W-1:0] name_acc = '0;
   logic [hss_pkg::HASH_W-1:0] var_hashes[$];
   logic [hss_pkg::HASH_W-1:0] func_hashes[$];
   logic [hss_pkg::HASH_W-1:0] main_key;

   sym_word_type words_to_send[$];
   lookup_type   lookups_due[$];
   ident_type    name_pool[$];
   ident_type    main_ident;

   int words_queued = 0;
   int words_accepted = 0;
   int lookups_checked = 0;
   int hits_seen = 0;
   int full_seen = 0;
   int mismatches = 0;
   int sender_idle_pct = 25;
   int receiver_idle_pct = 50;
   int hold_left = 0;
   bit hold_done = 1'b0;

   hashed_symbol_set_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_name_byte    (req_name_byte),
      .req_last_byte    (req_last_byte),
      .req_which_set    (req_which_set),
      .req_want_insert  (req_want_insert),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_inserted     (rsp_inserted),
      .rsp_set_full     (rsp_set_full),
      .rsp_name_hash    (rsp_name_hash),
      .rsp_main_defined (rsp_main_defined)
   );

   always #5 clock = ~clock;

   function automatic logic [hss_pkg::HASH_W-1:0] fold_char(
         logic [hss_pkg::HASH_W-1:0] h, logic [hss_pkg::HASH_W-1:0] c);
      logic [hss_pkg::HASH_W-1:0] t;
      t = h + c;
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic logic [hss_pkg::HASH_W-1:0] finalize_hash(
         logic [hss_pkg::HASH_W-1:0] h);
      logic [hss_pkg::HASH_W-1:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction

   function automatic bit has_hash(logic [hss_pkg::HASH_W-1:0] s[$],
                                   logic [hss_pkg::HASH_W-1:0] h);
      foreach (s[i])
         if (s[i] == h) return 1'b1;
      return 1'b0;
   endfunction

   // one accepted word; a final character owes one lookup result
   task automatic model_symbol_word(sym_word_type w);
      lookup_type                 r;
      logic [hss_pkg::HASH_W-1:0] h;
      bit                         room;
      if (w.op == hss_pkg::OP_CLEAR_VAR) begin
         var_hashes.delete();
         return;
      end
      name_acc = fold_char(name_acc, hss_pkg::HASH_W'(w.ch));
      if (!w.last) return;
      h = finalize_hash(name_acc);
      name_acc = '0;
      r.hash = h;
      r.inserted = 1'b0;
      r.set_full = 1'b0;
      if (w.fset == hss_pkg::SET_FUNC) begin
         r.found = has_hash(func_hashes, h);
         room = func_hashes.size() < hss_pkg::FUNC_DEPTH;
      end else begin
         r.found = has_hash(var_hashes, h);
         room = var_hashes.size() < hss_pkg::VAR_DEPTH;
      end
      if (w.ins && !r.found) begin
         if (room) begin
            r.inserted = 1'b1;
            if (w.fset == hss_pkg::SET_FUNC) func_hashes.push_back(h);
            else var_hashes.push_back(h);
         end else begin
            r.set_full = 1'b1;
         end
      end
      r.main_def = has_hash(func_hashes, main_key);
      lookups_due.push_back(r);
   endtask

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, what);
   endtask

   // sender
   always @(posedge clock) begin : drive
      sym_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            w.op = req_op;
            w.ch = req_name_byte;
            w.last = req_last_byte;
            w.fset = req_which_set;
            w.ins = req_want_insert;
            model_symbol_word(w);
            words_accepted <= words_accepted + 1;
         end
         if (words_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            w = words_to_send.pop_front();
            req_valid <= 1'b1;
            req_op <= w.op;
            req_name_byte <= w.ch;
            req_last_byte <= w.last;
            req_which_set <= w.fset;
            req_want_insert <= w.ins;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off once traffic is flowing
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && lookups_checked >= 120) begin
         rsp_stall <= 1'b1;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin : watch
      lookup_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lookups_due.size() == 0) begin
            report_mismatch($sformatf("result word with nothing owed: hash=%h",
                                      rsp_name_hash));
         end else begin
            want = lookups_due.pop_front();
            if (want.found !== rsp_found || want.inserted !== rsp_inserted ||
                want.set_full !== rsp_set_full || want.hash !== rsp_name_hash ||
                want.main_def !== rsp_main_defined)
               report_mismatch($sformatf(
                  "lookup %0d found/ins/full/hash/main exp %b/%b/%b/%h/%b got %b/%b/%b/%h/%b",
                  lookups_checked, want.found, want.inserted, want.set_full, want.hash,
                  want.main_def, rsp_found, rsp_inserted, rsp_set_full, rsp_name_hash,
                  rsp_main_defined));
            if (want.found) hits_seen <= hits_seen + 1;
            if (want.set_full) full_seen <= full_seen + 1;
         end
         lookups_checked <= lookups_checked + 1;
      end
   end

   task automatic queue_word(logic op, logic [hss_pkg::BYTE_W-1:0] ch, logic last,
                             logic fset, logic ins);
      sym_word_type w;
      w.op = op;
      w.ch = ch;
      w.last = last;
      w.fset = fset;
      w.ins = ins;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   task automatic queue_clear();
      queue_word(hss_pkg::OP_CLEAR_VAR, hss_pkg::BYTE_W'($urandom_range(127)),
                 1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // set and insert flags of non-final characters are don't-care
   task automatic queue_name(ident_type id, logic fset, logic ins, int clear_pct);
      for (int i = 0; i < id.len; i++) begin
         if (i != 0 && $urandom_range(99) < clear_pct) queue_clear();
         if (i == id.len - 1)
            queue_word(hss_pkg::OP_NAME_BYTE, id.chars[i], 1'b1, fset, ins);
         else
            queue_word(hss_pkg::OP_NAME_BYTE, id.chars[i], 1'b0, 1'($urandom),
                       1'($urandom));
      end
   endtask

   function automatic ident_type fresh_ident(int n);
      ident_type id;
      id.len = n;
      for (int i = 0; i < n; i++) id.chars[i] = hss_pkg::BYTE_W'($urandom_range(127));
      return id;
   endfunction

   // names mostly short, some reused so that lookups hit
   task automatic random_mix(int n_words, int clear_pct);
      int        stop;
      ident_type id;
      stop = words_queued + n_words;
      while (words_queued < stop) begin
         if ($urandom_range(99) < clear_pct) begin
            queue_clear();
         end else begin
            if (name_pool.size() != 0 && $urandom_range(99) < 40) begin
               id = name_pool[$urandom_range(name_pool.size() - 1)];
            end else begin
               id = fresh_ident(($urandom_range(99) < 10) ? 8 : $urandom_range(1, 5));
               name_pool.push_back(id);
               if (name_pool.size() > 150) void'(name_pool.pop_front());
            end
            queue_name(id, 1'($urandom), ($urandom_range(99) < 70), clear_pct);
         end
      end
   endtask

   task automatic fill_set(logic fset, int n);
      for (int i = 0; i < n; i++) queue_name(fresh_ident(2), fset, 1'b1, 0);
   endtask

   task automatic drain_words();
      while (words_to_send.size() != 0 || req_valid) @(negedge clock);
   endtask

   initial begin : stimulus
      string main_text;
      int    waited;
      main_text = "main";
      main_key = '0;
      main_ident.len = 4;
      for (int i = 0; i < 4; i++) begin
         main_ident.chars[i] = hss_pkg::BYTE_W'(main_text[i]);
         main_key = fold_char(main_key, hss_pkg::HASH_W'(main_ident.chars[i]));
      end
      main_key = finalize_hash(main_key);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, both sets, present/absent, clears
      queue_word(hss_pkg::OP_NAME_BYTE, 7'h00, 1'b1, hss_pkg::SET_VAR, 1'b0);
      queue_word(hss_pkg::OP_NAME_BYTE, 7'h7f, 1'b1, hss_pkg::SET_VAR, 1'b1);
      queue_word(hss_pkg::OP_NAME_BYTE, 7'h7f, 1'b1, hss_pkg::SET_VAR, 1'b1);
      queue_word(hss_pkg::OP_NAME_BYTE, 7'h7f, 1'b1, hss_pkg::SET_VAR, 1'b0);
      queue_word(hss_pkg::OP_CLEAR_VAR, 7'h7f, 1'b1, hss_pkg::SET_FUNC, 1'b1);
      queue_word(hss_pkg::OP_NAME_BYTE, 7'h7f, 1'b1, hss_pkg::SET_VAR, 1'b0);
      // clear between characters must leave the running hash alone
      queue_word(hss_pkg::OP_NAME_BYTE, main_ident.chars[0], 1'b0, hss_pkg::SET_FUNC, 1'b1);
      queue_word(hss_pkg::OP_NAME_BYTE, main_ident.chars[1], 1'b0, hss_pkg::SET_VAR, 1'b0);
      queue_word(hss_pkg::OP_CLEAR_VAR, 7'h00, 1'b0, hss_pkg::SET_VAR, 1'b0);
      queue_word(hss_pkg::OP_NAME_BYTE, main_ident.chars[2], 1'b0, hss_pkg::SET_FUNC, 1'b1);
      queue_word(hss_pkg::OP_NAME_BYTE, main_ident.chars[3], 1'b1, hss_pkg::SET_FUNC, 1'b0);
      queue_name(main_ident, hss_pkg::SET_FUNC, 1'b0, 0);
      queue_word(hss_pkg::OP_NAME_BYTE, 7'h00, 1'b1, hss_pkg::SET_FUNC, 1'b1);
      queue_word(hss_pkg::OP_NAME_BYTE, 7'h00, 1'b1, hss_pkg::SET_VAR, 1'b0);
      queue_word(hss_pkg::OP_NAME_BYTE, 7'h00, 1'b1, hss_pkg::SET_FUNC, 1'b0);
      queue_word(hss_pkg::OP_NAME_BYTE, 7'h7f, 1'b0, hss_pkg::SET_VAR, 1'b0);
      queue_word(hss_pkg::OP_NAME_BYTE, 7'h7f, 1'b1, hss_pkg::SET_FUNC, 1'b1);

      random_mix(380, 4);
      queue_name(main_ident, hss_pkg::SET_FUNC, 1'b1, 0);
      name_pool.push_back(main_ident);
      fill_set(hss_pkg::SET_FUNC, 70);
      random_mix(150, 4);
      drain_words();

      sender_idle_pct = 50;
      receiver_idle_pct = 25;
      queue_clear();
      fill_set(hss_pkg::SET_VAR, 280);
      random_mix(100, 0);
      drain_words();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      random_mix(600, 4);
      drain_words();

      waited = 0;
      while (lookups_due.size() != 0 && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      repeat (600) @(negedge clock);
      if (lookups_due.size() != 0) begin
         mismatches += lookups_due.size();
         $display("%0d lookup results never arrived", lookups_due.size());
      end

      $display("sent %0d words, checked %0d lookups (%0d hits, %0d inserts refused on full)",
               words_accepted, lookups_checked, hits_seen, full_seen);
      $display("covered both sets filled to capacity, mid-name clears, long output back-pressure");
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #(60_000_000);
      $display("timed out with %0d lookups outstanding", lookups_due.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
